// ===== hdl/tgt_pkg.sv =====
package tgt_pkg;

  // Grid geometry and register widths.
  localparam int GRID_SIDE_DEFAULT = 10;
  localparam int KEY_LOW_W = 64;
  localparam int KEY_HIGH_W = 57;
  localparam int KEY_W = KEY_LOW_W + KEY_HIGH_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MASK_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MASK_HIGH = 2'd1;

  // Mode codes carried by an input word.
  localparam logic [1:0] MODE_PLAIN_WRITE = 2'd0;
  localparam logic [1:0] MODE_CIPHER_READ = 2'd1;
  localparam logic [1:0] MODE_CIPHER_LOAD = 2'd2;
  localparam logic [1:0] MODE_PLAIN_READ = 2'd3;

  // Quarter-turns of the grille.
  localparam logic [1:0] QTURN_0 = 2'd0;
  localparam logic [1:0] QTURN_1 = 2'd1;
  localparam logic [1:0] QTURN_2 = 2'd2;
  localparam logic [1:0] QTURN_3 = 2'd3;

  typedef enum logic [1:0] {
    K_PLAIN_WRITE,
    K_CIPHER_READ,
    K_CIPHER_LOAD,
    K_PLAIN_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [7:0] data;
  } item_t;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_READ,
    MEM_WRITE,
    MEM_READ_CLEAR
  } mem_op_t;

  typedef struct packed {
    mem_op_t op;
    logic [7:0] wdata;
  } mem_req_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FIND,
    B_NEXT,
    B_MEM
  } back_state_t;

endpackage

// ===== hdl/tgt_front.sv =====
module tgt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  logic [1:0]     mode,
  input  logic [7:0]     data_in,
  output logic           q_valid,
  output tgt_pkg::item_t q_item,
  input  logic           q_pop
);
  import tgt_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  item_t            incoming;
  logic             push;

  // Decode the mode into the kind of work the back end performs.
  always_comb begin
    incoming.data = data_in;
    case (mode)
      MODE_PLAIN_WRITE: incoming.kind = K_PLAIN_WRITE;
      MODE_CIPHER_READ: incoming.kind = K_CIPHER_READ;
      MODE_CIPHER_LOAD: incoming.kind = K_CIPHER_LOAD;
      default:          incoming.kind = K_PLAIN_READ;
    endcase
  end

  assign item_ready = (count != CNTW'(QUEUE_DEPTH));
  assign push = item_valid && item_ready;
  assign q_valid = (count != '0);
  assign q_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, q_pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/tgt_grid_mem.sv =====
module tgt_grid_mem #(
  parameter int DEPTH = 100,
  parameter int AW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  tgt_pkg::mem_req_t req,
  input  logic [AW-1:0]     addr,
  output logic [7:0]        rdata
);
  import tgt_pkg::*;

  logic [7:0]       cells [DEPTH];
  logic [DEPTH-1:0] written;

  // A cell that was never written, or was cleared by a readout, reads zero.
  always_ff @(posedge clk) begin
    case (req.op)
      MEM_WRITE: cells[addr] <= req.wdata;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (req.op)
      MEM_READ, MEM_READ_CLEAR: rdata <= written[addr] ? cells[addr] : 8'd0;
      default:                  rdata <= rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else begin
      case (req.op)
        MEM_WRITE:      written[addr] <= 1'b1;
        MEM_READ_CLEAR: written[addr] <= 1'b0;
        default:        ;
      endcase
    end
  end

endmodule

// ===== hdl/tgt_back.sv =====
module tgt_back #(
  parameter int GRID_SIDE = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [tgt_pkg::KEY_LOW_W-1:0]    key_mask_low,
  input  logic [tgt_pkg::KEY_HIGH_W-1:0]   key_mask_high,
  input  logic                             key_changed,
  input  logic                             q_valid,
  input  tgt_pkg::item_t                   q_item,
  output logic                             q_pop,
  output tgt_pkg::mem_req_t                mem_req,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] mem_addr,
  input  logic [7:0]                       mem_rdata,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [7:0]                       data_out,
  output logic [3:0]                       row,
  output logic [3:0]                       column,
  output logic                             hit,
  output logic                             last
);
  import tgt_pkg::*;

  localparam int N = GRID_SIDE;
  localparam int CELLS = N * N;
  localparam int CW = $clog2(CELLS);
  localparam int RW = $clog2(N);
  localparam int SW = $clog2(N + 1);
  localparam logic [RW-1:0] NM1 = RW'(N - 1);
  localparam logic [CW-1:0] N_C = CW'(N);

  logic [KEY_W-1:0] key_all;
  logic [CELLS-1:0] key_cells;

  back_state_t state, state_next;
  op_kind_t    kind, kind_next;
  logic [7:0]  din, din_next;

  // Hole cursor, with a flag telling that it already stands on a hole.
  logic [1:0]    cur_turn, cur_turn_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [RW-1:0] cur_col, cur_col_next;
  logic          cur_hole, cur_hole_next;
  logic          exhausted, exhausted_next;

  logic [RW-1:0] cell_row, cell_row_next;
  logic [RW-1:0] cell_col, cell_col_next;

  // Row scanner position; a start column of N means nothing is left in that row.
  logic [1:0]    s_turn, s_turn_next;
  logic [RW-1:0] s_row, s_row_next;
  logic [SW-1:0] s_col, s_col_next;

  logic [RW-1:0] p_row, p_row_next;
  logic [RW-1:0] p_col, p_col_next;
  logic          pend_last, pend_last_next;

  logic          res_valid, res_valid_next;
  logic [7:0]    res_data, res_data_next;
  logic [RW-1:0] res_row, res_row_next;
  logic [RW-1:0] res_col, res_col_next;
  logic          res_hit, res_hit_next;
  logic          res_last, res_last_next;

  logic [RW-1:0] mr_a [N];
  logic [RW-1:0] mc_a [N];
  logic [CW-1:0] mi_a [N];
  logic [N-1:0]  hole_v;
  logic          row_found;
  logic [RW-1:0] fcol;
  logic          at_end;
  logic          out_free;
  logic [RW-1:0] a_row;
  logic [RW-1:0] a_col;

  assign key_all = {key_mask_high, key_mask_low};
  assign key_cells = key_all[CELLS-1:0];

  // One row of the rotated grille: map each scanned column back to its mask cell.
  always_comb begin
    for (int c = 0; c < N; c++) begin
      case (s_turn)
        QTURN_0: begin
          mr_a[c] = s_row;
          mc_a[c] = RW'(c);
        end
        QTURN_1: begin
          mr_a[c] = NM1 - RW'(c);
          mc_a[c] = s_row;
        end
        QTURN_2: begin
          mr_a[c] = NM1 - s_row;
          mc_a[c] = NM1 - RW'(c);
        end
        default: begin
          mr_a[c] = RW'(c);
          mc_a[c] = NM1 - s_row;
        end
      endcase
      mi_a[c] = CW'(mr_a[c]) * N_C + CW'(mc_a[c]);
      hole_v[c] = !key_cells[mi_a[c]] && (SW'(c) >= s_col);
    end
  end

  always_comb begin
    fcol = '0;
    for (int c = N - 1; c >= 0; c--) begin
      if (hole_v[c]) begin
        fcol = RW'(c);
      end
    end
  end

  assign row_found = |hole_v;
  assign at_end = (s_turn == QTURN_3) && (s_row == NM1);
  assign out_free = !res_valid || result_ready;

  assign a_row = (state == B_IDLE) ? cell_row : p_row;
  assign a_col = (state == B_IDLE) ? cell_col : p_col;
  assign mem_addr = CW'(a_row) * N_C + CW'(a_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next = kind;
    din_next = din;
    cur_turn_next = cur_turn;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    cur_hole_next = cur_hole;
    exhausted_next = exhausted;
    cell_row_next = cell_row;
    cell_col_next = cell_col;
    s_turn_next = s_turn;
    s_row_next = s_row;
    s_col_next = s_col;
    p_row_next = p_row;
    p_col_next = p_col;
    pend_last_next = pend_last;
    res_valid_next = res_valid && !result_ready;
    res_data_next = res_data;
    res_row_next = res_row;
    res_col_next = res_col;
    res_hit_next = res_hit;
    res_last_next = res_last;
    q_pop = 1'b0;
    mem_req.op = MEM_NONE;
    mem_req.wdata = din;

    // A new key makes the cached hole position stale.
    if (key_changed) begin
      cur_hole_next = 1'b0;
    end

    case (state)
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          kind_next = q_item.kind;
          din_next = q_item.data;
          case (q_item.kind)
            K_PLAIN_WRITE, K_PLAIN_READ: begin
              if (q_item.kind == K_PLAIN_WRITE && exhausted) begin
                // Grid full: the byte is dropped and echoed back.
                res_valid_next = 1'b1;
                res_data_next = q_item.data;
                res_row_next = '0;
                res_col_next = '0;
                res_hit_next = 1'b0;
                res_last_next = 1'b0;
              end else if (cur_hole) begin
                p_row_next = cur_row;
                p_col_next = cur_col;
                s_turn_next = cur_turn;
                s_row_next = cur_row;
                s_col_next = SW'(cur_col) + SW'(1);
                state_next = B_NEXT;
              end else begin
                s_turn_next = cur_turn;
                s_row_next = cur_row;
                s_col_next = SW'(cur_col);
                state_next = B_FIND;
              end
            end
            default: begin
              mem_req.op = (q_item.kind == K_CIPHER_READ) ? MEM_READ_CLEAR : MEM_WRITE;
              mem_req.wdata = q_item.data;
              p_row_next = cell_row;
              p_col_next = cell_col;
              pend_last_next = (cell_row == NM1) && (cell_col == NM1);
              if (cell_col == NM1) begin
                cell_col_next = '0;
                cell_row_next = (cell_row == NM1) ? '0 : cell_row + RW'(1);
              end else begin
                cell_col_next = cell_col + RW'(1);
              end
              // Reading out the final cell readies the grille for a new plaintext.
              if (q_item.kind == K_CIPHER_READ && cell_row == NM1 && cell_col == NM1) begin
                exhausted_next = 1'b0;
                cur_turn_next = QTURN_0;
                cur_row_next = '0;
                cur_col_next = '0;
                cur_hole_next = 1'b0;
              end
              state_next = B_MEM;
            end
          endcase
        end
      end

      B_FIND: begin
        if (row_found) begin
          p_row_next = s_row;
          p_col_next = fcol;
          s_col_next = SW'(fcol) + SW'(1);
          state_next = B_NEXT;
        end else if (at_end) begin
          // No hole is left from the cursor to the end of the last quarter-turn.
          cur_turn_next = QTURN_0;
          cur_row_next = '0;
          cur_col_next = '0;
          cur_hole_next = 1'b0;
          if (kind == K_PLAIN_WRITE) begin
            exhausted_next = 1'b1;
          end
          res_valid_next = 1'b1;
          res_data_next = (kind == K_PLAIN_READ) ? 8'd0 : din;
          res_row_next = '0;
          res_col_next = '0;
          res_hit_next = 1'b0;
          res_last_next = 1'b0;
          state_next = B_IDLE;
        end else begin
          s_col_next = '0;
          s_row_next = (s_row == NM1) ? '0 : s_row + RW'(1);
          s_turn_next = (s_row == NM1) ? s_turn + 2'd1 : s_turn;
        end
      end

      B_NEXT: begin
        if (row_found || at_end) begin
          if (row_found) begin
            cur_turn_next = s_turn;
            cur_row_next = s_row;
            cur_col_next = fcol;
            cur_hole_next = 1'b1;
            pend_last_next = 1'b0;
          end else begin
            cur_turn_next = QTURN_0;
            cur_row_next = '0;
            cur_col_next = '0;
            cur_hole_next = 1'b0;
            pend_last_next = 1'b1;
            if (kind == K_PLAIN_WRITE) begin
              exhausted_next = 1'b1;
            end
          end
          mem_req.op = (kind == K_PLAIN_WRITE) ? MEM_WRITE : MEM_READ;
          state_next = B_MEM;
        end else begin
          s_col_next = '0;
          s_row_next = (s_row == NM1) ? '0 : s_row + RW'(1);
          s_turn_next = (s_row == NM1) ? s_turn + 2'd1 : s_turn;
        end
      end

      B_MEM: begin
        res_valid_next = 1'b1;
        res_data_next = (kind == K_PLAIN_READ || kind == K_CIPHER_READ) ? mem_rdata : din;
        res_row_next = p_row;
        res_col_next = p_col;
        res_hit_next = 1'b1;
        res_last_next = pend_last;
        state_next = B_IDLE;
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_turn <= QTURN_0;
      cur_row <= '0;
      cur_col <= '0;
      cur_hole <= 1'b0;
      exhausted <= 1'b0;
      cell_row <= '0;
      cell_col <= '0;
      res_valid <= 1'b0;
    end else begin
      cur_turn <= cur_turn_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      cur_hole <= cur_hole_next;
      exhausted <= exhausted_next;
      cell_row <= cell_row_next;
      cell_col <= cell_col_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    din <= din_next;
    s_turn <= s_turn_next;
    s_row <= s_row_next;
    s_col <= s_col_next;
    p_row <= p_row_next;
    p_col <= p_col_next;
    pend_last <= pend_last_next;
    res_data <= res_data_next;
    res_row <= res_row_next;
    res_col <= res_col_next;
    res_hit <= res_hit_next;
    res_last <= res_last_next;
  end

  assign result_valid = res_valid;
  assign data_out = res_data;
  assign row = 4'(res_row);
  assign column = 4'(res_col);
  assign hit = res_hit;
  assign last = res_last;

endmodule

// ===== hdl/turning_grille_transposer_unit.sv =====
// Channel   Direction  Handshake                 Word
// item      in         item_valid / item_ready   mode, data_in
// result    out        result_valid / result_ready  data_out, row, column, hit, last
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A cipher load or cipher readout word leaves the queue and addresses the grid
// memory in B_IDLE; in B_MEM the registered read reaches the result register.
// A plaintext word goes from B_IDLE straight to B_NEXT when the cursor already
// stands on a hole, else through B_FIND first, and from B_NEXT on to B_MEM. The
// hole scanner steps through each further row it has to (at most 4 * GRID_SIDE
// rows); after a key write or a wrap of the hole cursor, the B_FIND scan from the
// cursor adds its own rows as well. Reset is synchronous; the grid reads zero at
// once through per-cell written bits, so there is no clearing pass. A two-word
// input queue keeps accepting until full while the back end scans or a result
// waits; the back end stalls only when the result register is still full.
module turning_grille_transposer_unit #(
  parameter int GRID_SIDE = tgt_pkg::GRID_SIDE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [1:0]                      mode,
  input  logic [7:0]                      data_in,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [7:0]                      data_out,
  output logic [3:0]                      row,
  output logic [3:0]                      column,
  output logic                            hit,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tgt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tgt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tgt_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW = $clog2(CELLS);

  logic [KEY_LOW_W-1:0]  key_mask_low;
  logic [KEY_HIGH_W-1:0] key_mask_high;
  logic                  cfg_write;

  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  mem_req_t mem_req;
  logic [CW-1:0] mem_addr;
  logic [7:0]    mem_rdata;

  // The key registers are always ready; a write to an unknown index is ignored.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask_low <= '0;
      key_mask_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_MASK_LOW:  key_mask_low <= cfg_data[KEY_LOW_W-1:0];
        REG_KEY_MASK_HIGH: key_mask_high <= cfg_data[KEY_HIGH_W-1:0];
        default:           ;
      endcase
    end
  end

  // Front end: accepts words and classifies them by mode into a short queue.
  tgt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .mode       (mode),
    .data_in    (data_in),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Back end: hole scanner, cursors and the result register.
  tgt_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .key_mask_low  (key_mask_low),
    .key_mask_high (key_mask_high),
    .key_changed   (cfg_write),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .mem_req       (mem_req),
    .mem_addr      (mem_addr),
    .mem_rdata     (mem_rdata),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .data_out      (data_out),
    .row           (row),
    .column        (column),
    .hit           (hit),
    .last          (last)
  );

  // Grid store with one read/write port and a registered read.
  tgt_grid_mem #(
    .DEPTH (CELLS),
    .AW    (CW)
  ) u_grid_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

endmodule
